/* rtl/core/rov_pkg.sv */
// shared types and constants for the rectangle overlay raster
`timescale 1ns / 1ps
`default_nettype none

package rov_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_DRAW  = 2'd2;

  // glyph shown where no rectangle covers the cell
  localparam logic [7:0] BLANK_GLYPH = 8'd32;

  // one stored rectangle, 32 bits
  typedef struct packed {
    logic [6:0] left;
    logic [4:0] top;
    logic [6:0] right;
    logic [4:0] bottom;
    logic [7:0] glyph;
  } rov_rect_t;

  // position flags from the scan counter
  typedef struct packed {
    logic last_col;
    logic last_row;
  } rov_pos_flags_t;

endpackage

`default_nettype wire

/* rtl/core/rov_rect_mem.sv */
// rectangle table: single write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module rov_rect_mem
  import rov_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire rov_rect_t        wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output rov_rect_t             rdata
);

  rov_rect_t mem [DEPTH];
  rov_rect_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/rov_scan_pos.sv */
// raster scan position counter with row and frame end flags
`timescale 1ns / 1ps
`default_nettype none

module rov_scan_pos
  import rov_pkg::*;
#(
  parameter int GRID_COLS = 80,
  parameter int GRID_ROWS = 25,
  parameter int CW        = 7,
  parameter int RW        = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic          advance,
  output logic [CW-1:0]      col,
  output logic [RW-1:0]      row,
  output rov_pos_flags_t     flags
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // last cell detection
  assign flags.last_col = (col_r == CW'(GRID_COLS - 1));
  assign flags.last_row = (row_r == RW'(GRID_ROWS - 1));

  // row-major advance, wrap after the last cell
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (advance) begin
      if (flags.last_col) begin
        col_nxt = '0;
        row_nxt = flags.last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

  // position stays inside the grid
  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(GRID_COLS - 1))
    else $error("scan column beyond grid");
  a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= RW'(GRID_ROWS - 1))
    else $error("scan row beyond grid");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !clear && flags.last_col && flags.last_row |=> col_r == '0 && row_r == '0)
    else $error("scan did not wrap after frame end");

endmodule

`default_nettype wire

/* rtl/core/rectangle_overlay_raster.sv */
// top level: command decode, newest-first table search and result register
`timescale 1ns / 1ps
`default_nettype none

// Character-grid compositor. A beat is taken when start is high and busy is
// low. Add writes the next free table entry and is dropped when the table
// holds MAX_RECTS rectangles. A draw beat with an empty table gives its
// result on the following cycle; otherwise the block reads the rectangle
// memory newest entry first, one entry per cycle, and stops at the first
// rectangle that covers the cell, or after the oldest entry; busy is high
// while it searches. The result appears on the out_ ports for one cycle with
// out_valid high and must be taken then; busy may already be low in that
// cycle, so a new beat can be given at once.

module rectangle_overlay_raster
  import rov_pkg::*;
#(
  parameter int MAX_RECTS = 16,
  parameter int GRID_COLS = 80,
  parameter int GRID_ROWS = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_action,
  input  wire logic [6:0] in_left,
  input  wire logic [4:0] in_top,
  input  wire logic [6:0] in_right,
  input  wire logic [4:0] in_bottom,
  input  wire logic [7:0] in_fill_glyph,
  output logic            out_valid,
  output logic [7:0]      out_cell_glyph,
  output logic [6:0]      out_cell_column,
  output logic [4:0]      out_cell_row,
  output logic            out_row_end,
  output logic            out_frame_end
);

  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int XW    = (CW > 7) ? CW : 7;
  localparam int YW    = (RW > 5) ? RW : 5;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_dec;
  logic             accept;

  logic             mem_we;
  rov_rect_t        mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  rov_rect_t        mem_rdata;

  logic             pos_clear;
  logic             emit;
  logic [7:0]       emit_glyph;
  logic [CW-1:0]    pos_col;
  logic [RW-1:0]    pos_row;
  rov_pos_flags_t   pos_flags;
  logic [XW-1:0]    col_x;
  logic [YW-1:0]    row_x;
  logic             hit;

  logic             out_valid_r;
  logic [7:0]       out_glyph_r;
  logic [6:0]       out_col_r;
  logic [4:0]       out_row_r;
  logic             out_row_end_r;
  logic             out_frame_end_r;

  assign busy      = (state_r == S_SEARCH);
  assign accept    = start && !busy;
  assign count_dec = count_r - 1'b1;

  // rectangle store
  rov_rect_mem #(
    .DEPTH (MAX_RECTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // scan position
  rov_scan_pos #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CW        (CW),
    .RW        (RW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (pos_clear),
    .advance (emit),
    .col     (pos_col),
    .row     (pos_row),
    .flags   (pos_flags)
  );

  // new entry from the input beat
  always_comb begin
    mem_wdata.left   = in_left;
    mem_wdata.top    = in_top;
    mem_wdata.right  = in_right;
    mem_wdata.bottom = in_bottom;
    mem_wdata.glyph  = in_fill_glyph;
  end

  // coverage test of the entry read last cycle
  assign col_x = XW'(pos_col);
  assign row_x = YW'(pos_row);
  assign hit = (XW'(mem_rdata.left) <= col_x) && (XW'(mem_rdata.right) >= col_x) &&
               (YW'(mem_rdata.top) <= row_x) && (YW'(mem_rdata.bottom) >= row_x);

  // read address: newest entry on a draw, then one step older each cycle
  assign mem_raddr = (state_r == S_IDLE) ? count_dec[IDX_W-1:0] : idx_r - 1'b1;

  // command decode and search sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    mem_we     = 1'b0;
    pos_clear  = 1'b0;
    emit       = 1'b0;
    emit_glyph = BLANK_GLYPH;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_CLEAR: begin
              count_nxt = '0;
              pos_clear = 1'b1;
            end
            ACT_ADD: begin
              if (count_r < CNT_W'(MAX_RECTS)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_DRAW: begin
              if (count_r == '0) begin
                emit = 1'b1;
              end else begin
                idx_nxt   = count_dec[IDX_W-1:0];
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          emit       = 1'b1;
          emit_glyph = mem_rdata.glyph;
          state_nxt  = S_IDLE;
        end else if (idx_r == '0) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit;
    end
  end

  // search index and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (emit) begin
      out_glyph_r     <= emit_glyph;
      out_col_r       <= col_x[6:0];
      out_row_r       <= row_x[4:0];
      out_row_end_r   <= pos_flags.last_col;
      out_frame_end_r <= pos_flags.last_col && pos_flags.last_row;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_glyph  = out_glyph_r;
  assign out_cell_column = out_col_r;
  assign out_cell_row    = out_row_r;
  assign out_row_end     = out_row_end_r;
  assign out_frame_end   = out_frame_end_r;

  // table fill never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECTS))
    else $error("rectangle count beyond capacity");
  // a search only runs over a non-empty table
  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> count_r != '0)
    else $error("search with empty table");
  // draw on a non-empty table starts a search
  a_draw_search: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == ACT_DRAW && count_r != '0 |=> busy)
    else $error("draw did not start search");
  // frame end only with row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

endmodule

`default_nettype wire

/* test/rov_result_checker.sv */
// result checker for the rectangle overlay raster: predicts each drawn cell and compares
`timescale 1ns / 1ps

module rov_result_checker
  import rov_pkg::*;
#(
  parameter int MAX_RECTS = 16,
  parameter int GRID_COLS = 80,
  parameter int GRID_ROWS = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [1:0] in_action,
  input  wire logic [6:0] in_left,
  input  wire logic [4:0] in_top,
  input  wire logic [6:0] in_right,
  input  wire logic [4:0] in_bottom,
  input  wire logic [7:0] in_fill_glyph,
  input  wire logic       out_valid,
  input  wire logic [7:0] out_cell_glyph,
  input  wire logic [6:0] out_cell_column,
  input  wire logic [4:0] out_cell_row,
  input  wire logic       out_row_end,
  input  wire logic       out_frame_end,
  output int              fail_count,
  output int              pending_cells
);

  // one predicted cell
  typedef struct {
    logic [7:0] glyph;
    logic [6:0] column;
    logic [4:0] row;
    logic       row_end;
    logic       frame_end;
  } drawn_cell_t;

  // own copy of the overlay state
  rov_rect_t   overlay[MAX_RECTS];
  int unsigned overlay_count;
  int unsigned raster_col;
  int unsigned raster_row;
  drawn_cell_t cells_due[$];
  int          mismatches = 0;

  // newest rectangle covering the cell wins, else blank
  function automatic logic [7:0] topmost_glyph(int unsigned col, int unsigned row);
    for (int i = int'(overlay_count) - 1; i >= 0; i--) begin
      if (overlay[i].left <= col && overlay[i].right >= col &&
          overlay[i].top <= row && overlay[i].bottom >= row)
        return overlay[i].glyph;
    end
    return BLANK_GLYPH;
  endfunction

  task automatic compare_field(string field, logic [7:0] expected, logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
      mismatches++;
    end
  endtask

  // watch both channels at every edge
  always @(posedge clk) begin : watch
    drawn_cell_t due;
    logic        last_col;
    logic        last_row;
    if (!rst_n) begin
      overlay_count = 0;
      raster_col    = 0;
      raster_row    = 0;
      cells_due.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid) begin
        if (cells_due.size() == 0) begin
          $error("result beat with no cell due: glyph %0d column %0d row %0d",
                 out_cell_glyph, out_cell_column, out_cell_row);
          mismatches++;
        end else begin
          due = cells_due.pop_front();
          compare_field("cell_glyph", due.glyph, out_cell_glyph);
          compare_field("cell_column", 8'(due.column), 8'(out_cell_column));
          compare_field("cell_row", 8'(due.row), 8'(out_cell_row));
          compare_field("row_end", 8'(due.row_end), 8'(out_row_end));
          compare_field("frame_end", 8'(due.frame_end), 8'(out_frame_end));
        end
      end
      // accepted input beat updates the predicted state
      if (start && !busy) begin
        case (in_action)
          ACT_CLEAR: begin
            overlay_count = 0;
            raster_col    = 0;
            raster_row    = 0;
          end
          ACT_ADD: begin
            if (overlay_count < MAX_RECTS) begin
              overlay[overlay_count] = '{left: in_left, top: in_top, right: in_right,
                                         bottom: in_bottom, glyph: in_fill_glyph};
              overlay_count++;
            end
          end
          ACT_DRAW: begin
            last_col        = (raster_col == GRID_COLS - 1);
            last_row        = (raster_row == GRID_ROWS - 1);
            due.glyph       = topmost_glyph(raster_col, raster_row);
            due.column      = raster_col[6:0];
            due.row         = raster_row[4:0];
            due.row_end     = last_col;
            due.frame_end   = last_col && last_row;
            cells_due.push_back(due);
            if (last_col) begin
              raster_col = 0;
              raster_row = last_row ? 0 : raster_row + 1;
            end else begin
              raster_col++;
            end
          end
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_cells <= cells_due.size();
  end

endmodule

/* test/rectangle_overlay_raster_tb.sv */
// testbench top for the rectangle overlay raster: stimulus, reset and verdict
`timescale 1ns / 1ps

module rectangle_overlay_raster_tb;
  import rov_pkg::*;

  localparam int MAX_RECTS = 16;
  localparam int GRID_COLS = 80;
  localparam int GRID_ROWS = 25;

  // the one action code that the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_action;
  logic [6:0] in_left;
  logic [4:0] in_top;
  logic [6:0] in_right;
  logic [4:0] in_bottom;
  logic [7:0] in_fill_glyph;
  logic       out_valid;
  logic [7:0] out_cell_glyph;
  logic [6:0] out_cell_column;
  logic [4:0] out_cell_row;
  logic       out_row_end;
  logic       out_frame_end;
  int         fail_count;
  int         pending_cells;
  int         burst_left = 0;
  int         beats_sent = 0;

  rectangle_overlay_raster #(
    .MAX_RECTS(MAX_RECTS),
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_left(in_left), .in_top(in_top),
    .in_right(in_right), .in_bottom(in_bottom), .in_fill_glyph(in_fill_glyph),
    .out_valid(out_valid), .out_cell_glyph(out_cell_glyph),
    .out_cell_column(out_cell_column), .out_cell_row(out_cell_row),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end)
  );

  rov_result_checker #(
    .MAX_RECTS(MAX_RECTS),
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_left(in_left), .in_top(in_top),
    .in_right(in_right), .in_bottom(in_bottom), .in_fill_glyph(in_fill_glyph),
    .out_valid(out_valid), .out_cell_glyph(out_cell_glyph),
    .out_cell_column(out_cell_column), .out_cell_row(out_cell_row),
    .out_row_end(out_row_end), .out_frame_end(out_frame_end),
    .fail_count(fail_count), .pending_cells(pending_cells)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop
  initial begin
    #10ms;
    $display("[rectangle_overlay_raster] ERROR");
    $finish;
  end

  function automatic rov_rect_t make_rect(int unsigned l, int unsigned t, int unsigned r,
                                          int unsigned b, int unsigned g);
    rov_rect_t rect;
    rect.left   = l[6:0];
    rect.top    = t[4:0];
    rect.right  = r[6:0];
    rect.bottom = b[4:0];
    rect.glyph  = g[7:0];
    return rect;
  endfunction

  // any bit pattern at all, also used as filler on beats that ignore the fields
  function automatic rov_rect_t noise_rect();
    return rov_rect_t'($urandom);
  endfunction

  // mostly well-formed rectangles inside the grid, sometimes anything
  function automatic rov_rect_t random_rect();
    rov_rect_t rect;
    rect = noise_rect();
    if ($urandom_range(4, 0) != 0) begin
      rect.left   = 7'($urandom_range(GRID_COLS - 1, 0));
      rect.right  = 7'($urandom_range(GRID_COLS - 1, rect.left));
      rect.top    = 5'($urandom_range(GRID_ROWS - 1, 0));
      rect.bottom = 5'($urandom_range(GRID_ROWS - 1, rect.top));
    end
    return rect;
  endfunction

  // present one beat, hold it until taken, then maybe idle between bursts
  task automatic issue_beat(input logic [1:0] act, input rov_rect_t rect);
    in_action     <= act;
    in_left       <= rect.left;
    in_top        <= rect.top;
    in_right      <= rect.right;
    in_bottom     <= rect.bottom;
    in_fill_glyph <= rect.glyph;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    if (act != ACT_UNUSED) beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(6, 0);
    end
  endtask

  // stimulus and verdict
  initial begin
    int n_adds;
    int n_draws;
    start         <= 1'b0;
    rst_n         <= 1'b0;
    in_action     <= ACT_CLEAR;
    in_left       <= '0;
    in_top        <= '0;
    in_right      <= '0;
    in_bottom     <= '0;
    in_fill_glyph <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, corner cases of the rectangle fields
    issue_beat(ACT_DRAW, noise_rect());
    issue_beat(ACT_ADD, make_rect(0, 0, GRID_COLS - 1, GRID_ROWS - 1, 8'h23));
    issue_beat(ACT_ADD, make_rect(GRID_COLS - 2, 0, 127, 31, 8'h50));
    issue_beat(ACT_ADD, make_rect(GRID_COLS - 1, GRID_ROWS - 1, GRID_COLS - 1,
                                  GRID_ROWS - 1, 8'hFF));
    issue_beat(ACT_ADD, make_rect(0, 0, 0, 0, 8'h00));
    // inverted columns, then inverted rows: both cover nothing
    issue_beat(ACT_ADD, make_rect(40, 0, 10, GRID_ROWS - 1, 8'h58));
    issue_beat(ACT_ADD, make_rect(0, 20, GRID_COLS - 1, 3, 8'h59));
    // wholly outside the grid
    issue_beat(ACT_ADD, make_rect(GRID_COLS, GRID_ROWS, 127, 31, 8'h5A));
    repeat (4) issue_beat(ACT_DRAW, noise_rect());
    issue_beat(ACT_UNUSED, make_rect(127, 31, 127, 31, 8'hFF));
    issue_beat(ACT_DRAW, make_rect(127, 31, 127, 31, 8'hFF));
    issue_beat(ACT_CLEAR, make_rect(127, 31, 127, 31, 8'hFF));
    issue_beat(ACT_DRAW, noise_rect());
    issue_beat(ACT_ADD, make_rect(3, 0, 5, 0, 8'h2A));
    repeat (6) issue_beat(ACT_DRAW, noise_rect());

    // random: mostly clear, fill, draw sequences, some of them overfilling the table
    while (beats_sent < 620) begin
      if ($urandom_range(9, 0) < 8) begin
        if ($urandom_range(1, 0) != 0) issue_beat(ACT_CLEAR, noise_rect());
        n_adds = $urandom_range(20, 0);
        repeat (n_adds) issue_beat(ACT_ADD, random_rect());
        n_draws = $urandom_range(40, 1);
        repeat (n_draws) begin
          if ($urandom_range(9, 0) == 0) issue_beat(ACT_ADD, random_rect());
          issue_beat(ACT_DRAW, noise_rect());
        end
      end else begin
        repeat ($urandom_range(8, 1)) issue_beat(2'($urandom_range(3, 0)), noise_rect());
      end
    end

    // two full rows and a little into the third, with borders drawn
    issue_beat(ACT_CLEAR, noise_rect());
    issue_beat(ACT_ADD, make_rect(0, 0, GRID_COLS - 1, 0, 8'h2D));
    issue_beat(ACT_ADD, make_rect(0, GRID_ROWS - 1, GRID_COLS - 1, GRID_ROWS - 1, 8'h3D));
    issue_beat(ACT_ADD, make_rect(GRID_COLS - 1, 0, GRID_COLS - 1, GRID_ROWS - 1, 8'h7C));
    issue_beat(ACT_ADD, make_rect(GRID_COLS - 1, GRID_ROWS - 1, GRID_COLS - 1,
                                  GRID_ROWS - 1, 8'h2B));
    repeat (2 * GRID_COLS + 3) issue_beat(ACT_DRAW, noise_rect());

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_cells != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[rectangle_overlay_raster] OK");
    end else begin
      $display("[rectangle_overlay_raster] ERROR");
    end
    $finish;
  end

endmodule

/* rectangle_overlay_raster.f */
rtl/core/rov_pkg.sv
rtl/core/rov_rect_mem.sv
rtl/core/rov_scan_pos.sv
rtl/core/rectangle_overlay_raster.sv
test/rov_result_checker.sv
test/rectangle_overlay_raster_tb.sv
